// ===== hw/rtl/q2rp_pkg.sv =====
package q2rp_pkg;

    // Field widths
    localparam int QW = 16;   // quaternion component, Q2.14
    localparam int TW = 34;   // sine/cosine terms in 2^-28 units
    localparam int CW = 37;   // CORDIC vector datapath
    localparam int ZW = 34;   // angle accumulator in 2^-30 rad
    localparam int RW = 29;   // square root result bits
    localparam int VW = 57;   // square root radicand bits
    localparam int ROLL_W  = 16;
    localparam int PITCH_W = 15;

    localparam int DEF_CORDIC_STEPS = 16;
    localparam int MAX_STEPS        = 32;

    localparam int ROLL_MAX_I  = 25736;
    localparam int PITCH_MAX_I = 12868;

    localparam logic signed [TW-1:0] ONE_Q28   = TW'(64'sd268435456);
    localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(64'sd1686629713);
    localparam logic signed [PITCH_W-1:0] PITCH_MAX = PITCH_W'(PITCH_MAX_I);

    // Terms handed from the front end through the root unit
    typedef struct packed {
        logic signed [TW-1:0] sr;   // roll numerator
        logic signed [TW-1:0] cr;   // roll denominator
        logic signed [TW-1:0] s;    // sine of pitch
        logic                 sat;  // |s| >= 1
    } t_terms;

    // atan(2^-i) in 2^-30 rad, truncated up to i = 26 and rounded beyond
    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/q2rp_in_if.sv =====
interface q2rp_in_if;
    import q2rp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [QW-1:0] quat_w;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;

    modport source(output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink(input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// ===== hw/rtl/q2rp_out_if.sv =====
interface q2rp_out_if;
    import q2rp_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [ROLL_W-1:0]  roll_angle;
    logic signed [PITCH_W-1:0] pitch_angle;
    logic                      pitch_saturated;

    modport source(output valid, roll_angle, pitch_angle, pitch_saturated, input ready);
    modport sink(input valid, roll_angle, pitch_angle, pitch_saturated, output ready);
endinterface

// ===== hw/rtl/q2rp_terms.sv =====
module q2rp_terms (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic signed [q2rp_pkg::QW-1:0] i_quat_w,
    input  logic signed [q2rp_pkg::QW-1:0] i_quat_x,
    input  logic signed [q2rp_pkg::QW-1:0] i_quat_y,
    input  logic signed [q2rp_pkg::QW-1:0] i_quat_z,
    output logic                           o_valid,
    output q2rp_pkg::t_terms               o_terms,
    output logic [q2rp_pkg::VW-1:0]        o_rad
);
    import q2rp_pkg::*;

    logic signed [2*QW-1:0] r_wx, r_yz, r_wy, r_zx, r_xx, r_yy;
    logic signed [2*QW-1:0] n_wx, n_yz, n_wy, n_zx, n_xx, n_yy;
    logic                   r_v1, r_v2, r_v3, r_v4;
    t_terms                 r_t2, r_t3, r_t4, n_t2;
    logic signed [RW-1:0]   s_trunc;
    logic signed [VW:0]     r_sq, n_sq;
    logic [VW:0]            n_rad;
    logic [VW-1:0]          r_rad;

    // Stage 1: products
    always_comb begin
        n_wx = i_quat_w * i_quat_x;
        n_yz = i_quat_y * i_quat_z;
        n_wy = i_quat_w * i_quat_y;
        n_zx = i_quat_z * i_quat_x;
        n_xx = i_quat_x * i_quat_x;
        n_yy = i_quat_y * i_quat_y;
    end

    // Stage 2: doubled sums and pole test
    always_comb begin
        n_t2.sr  = (TW'(r_wx) + TW'(r_yz)) <<< 1;
        n_t2.cr  = ONE_Q28 - ((TW'(r_xx) + TW'(r_yy)) <<< 1);
        n_t2.s   = (TW'(r_wy) - TW'(r_zx)) <<< 1;
        n_t2.sat = (n_t2.s >= ONE_Q28) || (n_t2.s <= -ONE_Q28);
    end

    // Stage 3: square of s, meaningful only off the pole
    assign s_trunc = r_t2.s[RW-1:0];
    assign n_sq    = (VW+1)'(s_trunc) * (VW+1)'(s_trunc);

    // Stage 4: radicand 1 - s^2
    assign n_rad = ((VW+1)'(1) << (VW-1)) - r_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wx  <= n_wx;
            r_yz  <= n_yz;
            r_wy  <= n_wy;
            r_zx  <= n_zx;
            r_xx  <= n_xx;
            r_yy  <= n_yy;
            r_t2  <= n_t2;
            r_t3  <= r_t2;
            r_sq  <= n_sq;
            r_t4  <= r_t3;
            r_rad <= n_rad[VW-1:0];
        end
    end

    assign o_valid = r_v4;
    assign o_terms = r_t4;
    assign o_rad   = r_rad;

endmodule

// ===== hw/rtl/q2rp_sqrt.sv =====
module q2rp_sqrt (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  q2rp_pkg::t_terms        i_terms,
    input  logic [q2rp_pkg::VW-1:0] i_rad,
    output logic                    o_valid,
    output q2rp_pkg::t_terms        o_terms,
    output logic [q2rp_pkg::RW-1:0] o_root
);
    import q2rp_pkg::*;

    // One result bit per stage, restoring digit recurrence
    logic          r_vld [RW];
    t_terms        r_t   [RW];
    logic [VW-1:0] r_v   [RW];
    logic [VW:0]   r_res [RW];

    for (genvar j = 0; j < RW; j++) begin : g_stage
        localparam logic [VW:0] BIT = (VW+1)'(1) << (2*(RW-1-j));
        logic          s_vld;
        t_terms        s_t;
        logic [VW-1:0] s_v, n_v;
        logic [VW:0]   s_res, n_res, s_sum;

        if (j == 0) begin : g_first
            assign s_vld = i_valid;
            assign s_t   = i_terms;
            assign s_v   = i_rad;
            assign s_res = '0;
        end else begin : g_next
            assign s_vld = r_vld[j-1];
            assign s_t   = r_t[j-1];
            assign s_v   = r_v[j-1];
            assign s_res = r_res[j-1];
        end

        // Subtract the trial value when it fits
        always_comb begin
            s_sum = s_res + BIT;
            if ({1'b0, s_v} >= s_sum) begin
                n_v   = s_v - s_sum[VW-1:0];
                n_res = (s_res >> 1) + BIT;
            end else begin
                n_v   = s_v;
                n_res = s_res >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_t[j]   <= s_t;
                r_v[j]   <= n_v;
                r_res[j] <= n_res;
            end
        end
    end

    assign o_valid = r_vld[RW-1];
    assign o_terms = r_t[RW-1];
    assign o_root  = r_res[RW-1][RW-1:0];

endmodule

// ===== hw/rtl/q2rp_cordic.sv =====
module q2rp_cordic #(
    parameter int STEPS = q2rp_pkg::DEF_CORDIC_STEPS,
    parameter int LIM   = q2rp_pkg::ROLL_MAX_I,
    parameter int OW    = q2rp_pkg::ROLL_W
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic signed [q2rp_pkg::TW-1:0] i_y,
    input  logic signed [q2rp_pkg::TW-1:0] i_x,
    output logic                           o_valid,
    output logic signed [OW-1:0]           o_angle
);
    import q2rp_pkg::*;

    localparam int N  = (STEPS > MAX_STEPS) ? MAX_STEPS : STEPS;
    localparam int QB = ZW - 17;
    localparam logic signed [ZW-1:0] RND  = ZW'(65536);
    localparam logic signed [QB-1:0] LIMV = QB'(LIM);

    logic                 r_pv, r_pzero;
    logic signed [CW-1:0] r_px, r_py, n_px, n_py, s_xe, s_ye;
    logic signed [ZW-1:0] r_pz, n_pz;

    // Pre-rotation into the right half plane
    always_comb begin
        s_xe = CW'(i_x);
        s_ye = CW'(i_y);
        n_px = s_xe;
        n_py = s_ye;
        n_pz = '0;
        if (s_xe < 0) begin
            if (s_ye >= 0) begin
                n_px = s_ye;
                n_py = -s_xe;
                n_pz = HALF_PI_Z;
            end else begin
                n_px = -s_ye;
                n_py = s_xe;
                n_pz = -HALF_PI_Z;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (i_en) begin
            r_pv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px    <= n_px;
            r_py    <= n_py;
            r_pz    <= n_pz;
            r_pzero <= (i_x == 0) && (i_y == 0);
        end
    end

    // One micro-rotation per stage
    logic                 r_vld  [N];
    logic                 r_zero [N];
    logic signed [CW-1:0] r_x    [N];
    logic signed [CW-1:0] r_y    [N];
    logic signed [ZW-1:0] r_z    [N];

    for (genvar i = 0; i < N; i++) begin : g_iter
        logic                 s_vld, s_zero;
        logic signed [CW-1:0] s_x, s_y, n_x, n_y;
        logic signed [ZW-1:0] s_z, n_z, s_at;

        if (i == 0) begin : g_first
            assign s_vld  = r_pv;
            assign s_zero = r_pzero;
            assign s_x    = r_px;
            assign s_y    = r_py;
            assign s_z    = r_pz;
        end else begin : g_next
            assign s_vld  = r_vld[i-1];
            assign s_zero = r_zero[i-1];
            assign s_x    = r_x[i-1];
            assign s_y    = r_y[i-1];
            assign s_z    = r_z[i-1];
        end

        assign s_at = $signed({2'b00, atan_lut(5'(i))});

        always_comb begin
            if (s_y > 0) begin
                n_x = s_x + (s_y >>> i);
                n_y = s_y - (s_x >>> i);
                n_z = s_z + s_at;
            end else begin
                n_x = s_x - (s_y >>> i);
                n_y = s_y + (s_x >>> i);
                n_z = s_z - s_at;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i]    <= n_x;
                r_y[i]    <= n_y;
                r_z[i]    <= n_z;
                r_zero[i] <= s_zero;
            end
        end
    end

    // Round to 2^-13 rad (Q3.13 at OW = 16) and clamp
    logic signed [ZW-1:0] s_rz;
    logic signed [QB-1:0] s_q, n_q;
    logic                 r_ov;
    logic signed [OW-1:0] r_ang;

    always_comb begin
        s_rz = r_z[N-1] + RND;
        s_q  = s_rz[ZW-1:17];
        n_q  = s_q;
        if (s_q > LIMV) begin
            n_q = LIMV;
        end
        if (s_q < -LIMV) begin
            n_q = -LIMV;
        end
        if (r_zero[N-1]) begin
            n_q = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_vld[N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang <= n_q[OW-1:0];
        end
    end

    assign o_valid = r_ov;
    assign o_angle = r_ang;

endmodule

// ===== hw/rtl/quaternion_to_roll_pitch.sv =====
// Quaternion to roll/pitch (ZYX): takes one Q2.14 quaternion per cycle while not stalled and
// returns roll in Q3.13 and pitch in Q2.13 radians (CORDIC_STEPS above 32 count as 32): the
// front end registers the products, the sine/cosine terms, the square of the sine and the
// radicand, the square root for the pitch cosine resolves one bit per stage over 29 stages, and
// two CORDIC lanes run one micro-rotation per stage with a pre-rotation and a rounding stage.
// A stall at the output freezes the whole pipeline; ready is high whenever the output
// register is empty or being taken. pitch_saturated flags |sin pitch| >= 1, with pitch then
// pinned to +/-pi/2.
module quaternion_to_roll_pitch #(
    parameter int CORDIC_STEPS = q2rp_pkg::DEF_CORDIC_STEPS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    q2rp_in_if.sink           i_in,
    q2rp_out_if.source        o_out
);
    import q2rp_pkg::*;

    localparam int N   = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
    localparam int LAT = N + 2;

    logic              s_en;
    logic              s_tv, s_qv, s_rv, s_pv;
    t_terms            s_tt, s_qt;
    logic [VW-1:0]     s_rad;
    logic [RW-1:0]     s_root;
    logic signed [ROLL_W-1:0]  s_roll;
    logic signed [PITCH_W-1:0] s_pitch;

    // Advance whenever the output slot is free or being drained
    assign s_en       = !s_rv || o_out.ready;
    assign i_in.ready = s_en;

    q2rp_terms u_terms (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (s_en),
        .i_valid  (i_in.valid),
        .i_quat_w (i_in.quat_w),
        .i_quat_x (i_in.quat_x),
        .i_quat_y (i_in.quat_y),
        .i_quat_z (i_in.quat_z),
        .o_valid  (s_tv),
        .o_terms  (s_tt),
        .o_rad    (s_rad)
    );

    q2rp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_valid (s_tv),
        .i_terms (s_tt),
        .i_rad   (s_rad),
        .o_valid (s_qv),
        .o_terms (s_qt),
        .o_root  (s_root)
    );

    q2rp_cordic #(
        .STEPS (CORDIC_STEPS),
        .LIM   (ROLL_MAX_I),
        .OW    (ROLL_W)
    ) u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_valid (s_qv),
        .i_y     (s_qt.sr),
        .i_x     (s_qt.cr),
        .o_valid (s_rv),
        .o_angle (s_roll)
    );

    q2rp_cordic #(
        .STEPS (CORDIC_STEPS),
        .LIM   (PITCH_MAX_I),
        .OW    (PITCH_W)
    ) u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_valid (s_qv),
        .i_y     (s_qt.s),
        .i_x     (TW'(s_root)),
        .o_valid (s_pv),
        .o_angle (s_pitch)
    );

    // Carry the pole flag and sign alongside the CORDIC lanes
    logic r_sat [LAT];
    logic r_neg [LAT];

    for (genvar k = 0; k < LAT; k++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (s_en) begin
                if (k == 0) begin
                    r_sat[k] <= s_qt.sat;
                    r_neg[k] <= s_qt.s[TW-1];
                end else begin
                    r_sat[k] <= r_sat[(k == 0) ? 0 : k-1];
                    r_neg[k] <= r_neg[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    assign o_out.valid           = s_rv;
    assign o_out.roll_angle      = s_roll;
    assign o_out.pitch_saturated = r_sat[LAT-1];
    assign o_out.pitch_angle     = !r_sat[LAT-1] ? s_pitch :
                                   (r_neg[LAT-1] ? -PITCH_MAX : PITCH_MAX);

`ifndef SYNTHESIS
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_rv == s_pv)
        else $error("roll and pitch lanes out of step");

    a_sat_pinned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.pitch_saturated) |->
        (o_out.pitch_angle == PITCH_MAX || o_out.pitch_angle == -PITCH_MAX))
        else $error("saturated pitch not at the pole");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import q2rp_pkg::*;

    localparam int STEPS   = DEF_CORDIC_STEPS;
    localparam int LATENCY = 4 + 29 + STEPS + 2;

    typedef struct packed {
        logic signed [QW-1:0] w;
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
        logic signed [QW-1:0] z;
    } t_quat;

    typedef struct packed {
        logic signed [ROLL_W-1:0]  roll;
        logic signed [PITCH_W-1:0] pitch;
        logic                      sat;
    } t_angles;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    q2rp_in_if  in_ch();
    q2rp_out_if out_ch();

    quaternion_to_roll_pitch uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always #10 i_clk = ~i_clk;

    t_quat   quat_queue[$];
    t_angles angle_queue[$];
    int      n_sent = 0;
    int      n_fail = 0;
    bit      paused_once = 0;
    int      hold_cnt = 0;
    bit      hold_done = 0;

    const longint atan_rom[32] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
        64'h00000001, 64'h00000000
    };

    // floor integer square root
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // vectoring CORDIC, result in Q3.13 clamped to +-lim
    function automatic longint vec_angle(input longint yy, input longint xx,
                                         input longint lim);
        longint acc;
        longint t;
        longint dx;
        longint dy;
        longint r;
        acc = 0;
        if (xx == 0 && yy == 0) return 0;
        if (xx < 0) begin
            t = xx;
            if (yy >= 0) begin
                xx = yy; yy = -t; acc = HALF_PI_Z;
            end else begin
                xx = -yy; yy = t; acc = -64'sd1686629713;
            end
        end
        for (int i = 0; i < STEPS && i < MAX_STEPS; i++) begin
            dx = yy >>> i;
            dy = xx >>> i;
            if (yy > 0) begin
                xx += dx; yy -= dy; acc += atan_rom[i];
            end else begin
                xx -= dx; yy += dy; acc -= atan_rom[i];
            end
        end
        r = (acc + (64'sd1 <<< 16)) >>> 17;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic t_angles quat_to_angles(input t_quat q);
        longint w, x, y, z, sr, cr, s, c, p;
        t_angles a;
        w = q.w; x = q.x; y = q.y; z = q.z;
        sr = 2 * (w * x + y * z);
        cr = (64'sd1 <<< 28) - 2 * (x * x + y * y);
        s  = 2 * (w * y - z * x);
        a.roll = ROLL_W'(vec_angle(sr, cr, ROLL_MAX_I));
        if (s >= (64'sd1 <<< 28) || s <= -(64'sd1 <<< 28)) begin
            p = (s > 0) ? PITCH_MAX_I : -PITCH_MAX_I;
            a.sat = 1'b1;
        end else begin
            c = int_sqrt((64'd1 << 56) - longint'(s * s));
            p = vec_angle(s, c, PITCH_MAX_I);
            a.sat = 1'b0;
        end
        a.pitch = PITCH_W'(p);
        return a;
    endfunction

    function automatic t_quat mk(input int w, input int x, input int y, input int z);
        t_quat q;
        q.w = QW'(w); q.x = QW'(x); q.y = QW'(y); q.z = QW'(z);
        return q;
    endfunction

    // append one item to the stimulus queue
    function automatic void put_quat(input t_quat q);
        quat_queue = {quat_queue, q};
    endfunction

    function automatic int sender_idle_pct();
        if (n_sent < 450) return 34;
        if (n_sent < 900) return 54;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (n_sent < 450) return 54;
        if (n_sent < 900) return 34;
        return 0;
    endfunction

    // driver: hold an offered item until transfer, then offer the next
    always @(posedge i_clk) begin
        bit   take;
        bit   pause;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            take = in_ch.valid && in_ch.ready;
            if (take) begin
                angle_queue = {angle_queue, quat_to_angles({in_ch.quat_w, in_ch.quat_x,
                                                            in_ch.quat_y, in_ch.quat_z})};
                n_sent++;
            end
            if (in_ch.valid && !take) begin
                // keep offering
            end else begin
                pause = 0;
                if (n_sent == 700 && !paused_once) begin
                    if (angle_queue.size() == 0) paused_once = 1;
                    else pause = 1;
                end
                if (!pause && quat_queue.size() > 0 &&
                    $urandom_range(99) >= sender_idle_pct()) begin
                    {in_ch.quat_w, in_ch.quat_x, in_ch.quat_y, in_ch.quat_z}
                        <= quat_queue.pop_front();
                    in_ch.valid <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver back-pressure, with one long hold-off late in the run
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            out_ch.ready <= 1'b0;
        end else if (n_sent >= 1000 && !hold_done) begin
            hold_done <= 1;
            hold_cnt <= 300;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    // monitor: compare each transfer against the oldest prediction
    always @(posedge i_clk) begin
        t_angles want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (angle_queue.size() == 0) begin
                $display("%0t: unexpected result roll=%0d pitch=%0d sat=%0b", $time,
                         out_ch.roll_angle, out_ch.pitch_angle, out_ch.pitch_saturated);
                n_fail++;
            end else begin
                want = angle_queue.pop_front();
                if (out_ch.roll_angle !== want.roll) begin
                    $display("%0t: roll expected %0d actual %0d", $time,
                             want.roll, out_ch.roll_angle);
                    n_fail++;
                end
                if (out_ch.pitch_angle !== want.pitch) begin
                    $display("%0t: pitch expected %0d actual %0d", $time,
                             want.pitch, out_ch.pitch_angle);
                    n_fail++;
                end
                if (out_ch.pitch_saturated !== want.sat) begin
                    $display("%0t: saturated expected %0b actual %0b", $time,
                             want.sat, out_ch.pitch_saturated);
                    n_fail++;
                end
            end
        end
    end

    // stimulus and end of run
    initial begin
        real rw, rx, ry, rz, nrm;
        int  kind;

        // directed: zero vector, identity, extremes, pitch poles, roll quadrants
        put_quat(mk(0, 0, 0, 0));
        put_quat(mk(16384, 0, 0, 0));
        put_quat(mk(-16384, 0, 0, 0));
        put_quat(mk(0, 16384, 0, 0));
        put_quat(mk(0, -16384, 0, 0));
        put_quat(mk(11585, 11585, 0, 0));
        put_quat(mk(11585, -11585, 0, 0));
        put_quat(mk(11585, 0, 11585, 0));
        put_quat(mk(11585, 0, -11585, 0));
        put_quat(mk(11586, 0, 11586, 0));
        put_quat(mk(16384, 0, 16384, 0));
        put_quat(mk(0, 16384, 0, 16384));
        put_quat(mk(0, -16384, 0, 16384));
        put_quat(mk(16384, 16384, 16384, 16384));
        put_quat(mk(-16384, -16384, -16384, -16384));
        put_quat(mk(16384, -16384, 16384, -16384));
        put_quat(mk(32767, 32767, 32767, 32767));
        put_quat(mk(-32768, -32768, -32768, -32768));
        put_quat(mk(-32768, 32767, -32768, 32767));
        put_quat(mk(8192, 8192, 8192, 8192));
        put_quat(mk(1, 0, 0, 0));
        put_quat(mk(0, 0, 1, 0));

        // random: mostly unit quaternions, some within +-1.0 and some full-width noise
        for (int n = 0; n < 1300; n++) begin
            kind = $urandom_range(99);
            if (kind < 75) begin
                rw = $urandom_range(65535) - 32767.5;
                rx = $urandom_range(65535) - 32767.5;
                ry = $urandom_range(65535) - 32767.5;
                rz = $urandom_range(65535) - 32767.5;
                nrm = $sqrt(rw * rw + rx * rx + ry * ry + rz * rz);
                put_quat(mk($rtoi(rw / nrm * 16384.0), $rtoi(rx / nrm * 16384.0),
                            $rtoi(ry / nrm * 16384.0), $rtoi(rz / nrm * 16384.0)));
            end else if (kind < 88) begin
                put_quat(mk(int'($urandom_range(32768)) - 16384,
                            int'($urandom_range(32768)) - 16384,
                            int'($urandom_range(32768)) - 16384,
                            int'($urandom_range(32768)) - 16384));
            end else begin
                put_quat(mk($urandom, $urandom, $urandom, $urandom));
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (quat_queue.size() == 0 && !in_ch.valid);
        wait (angle_queue.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("** quaternion_to_roll_pitch: PASSED **");
        end else begin
            $display("** quaternion_to_roll_pitch: FAILED **");
        end
        $finish;
    end

    // timeout
    initial begin
        #20_000_000;
        $display("** quaternion_to_roll_pitch: FAILED **");
        $finish;
    end

endmodule

// ===== quaternion_to_roll_pitch.f =====
hw/rtl/q2rp_pkg.sv
hw/rtl/q2rp_in_if.sv
hw/rtl/q2rp_out_if.sv
hw/rtl/q2rp_terms.sv
hw/rtl/q2rp_sqrt.sv
hw/rtl/q2rp_cordic.sv
hw/rtl/quaternion_to_roll_pitch.sv
tb/sv/tb.sv
